FILE: design/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg: shared definitions for the JSON string unescape unit
// Character codes, decoder phase codes and the result record type.
// ----------------------------------------------------------------------------
package jsu_pkg;

	// Characters that the decoder recognizes.
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_B = 8'h62;
	localparam logic [7:0] CH_F = 8'h66;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_R = 8'h72;
	localparam logic [7:0] CH_T = 8'h74;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Decoder phases.
	localparam logic [1:0] PH_WS = 2'd0;
	localparam logic [1:0] PH_STR = 2'd1;
	localparam logic [1:0] PH_ESC = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	// One result item.
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       string_done;
		logic       run_last;
	} res_t;

	localparam res_t RES_NONE = '{out_byte: 8'h00, byte_valid: 1'b0,
		string_done: 1'b0, run_last: 1'b0};

endpackage

FILE: design/json_string_unescape_unit.sv
// ----------------------------------------------------------------------------
// json_string_unescape_unit: byte-wide JSON string token decoder
// Skips leading whitespace, strips the quotes and decodes simple escapes.
// ----------------------------------------------------------------------------
// The unit takes one encoded byte per request on the slave stream, with
// s_tlast on the final byte of each text, and returns the decoded string on
// the master stream. Every byte is decoded in the cycle it is accepted and
// its results are written straight into a three-entry result queue, so the
// unit takes one input byte per clock while the queue has room. A byte
// yields zero, one or two results; an unknown escape yields two (a
// backslash, then the byte). The slave side is ready while the queue holds
// at most one result, so a two-result byte or a stalled master side holds
// the slave side off until the queue drains again. m_tuser carries
// byte_valid and string_done, and m_tlast marks the last result caused by
// a byte whose s_tlast was set. Results with byte_valid low carry a zero
// byte. There is no configuration and no clearing pass after reset.
module json_string_unescape_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] in_byte
	input  logic       s_tlast,  // in_last
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] out_byte
	output logic [1:0] m_tuser,  // [0] byte_valid, [1] string_done
	output logic       m_tlast   // run_last
);
	import jsu_pkg::*;

	localparam int QDEPTH = 3;

	logic [1:0] phase_q;
	logic [1:0] phase_d;
	logic [1:0] cnt_q;
	logic [1:0] cnt_d;
	logic [1:0] base;
	logic [1:0] n_res;
	res_t       res0;
	res_t       res1;
	res_t       que_q [QDEPTH];
	res_t       que_d [QDEPTH];
	logic       push;
	logic       pop;
	logic       is_blank;
	logic       known;
	logic [7:0] unesc;

	// The queue always has room for two results when a request is taken.
	assign s_tready = (cnt_q <= 2'd1);
	assign m_tvalid = (cnt_q != 2'd0);
	assign push = s_tvalid & s_tready;
	assign pop = m_tvalid & m_tready;

	assign m_tdata = que_q[0].out_byte;
	assign m_tuser = {que_q[0].string_done, que_q[0].byte_valid};
	assign m_tlast = que_q[0].run_last;

	// Escape lookup: known escapes map to one byte, anything else is kept.
	always_comb begin
		known = 1'b1;
		case (s_tdata)
			CH_QUOTE:  unesc = CH_QUOTE;
			CH_BSLASH: unesc = CH_BSLASH;
			CH_SLASH:  unesc = CH_SLASH;
			CH_B:      unesc = CH_BS;
			CH_F:      unesc = CH_FF;
			CH_N:      unesc = CH_LF;
			CH_R:      unesc = CH_CR;
			CH_T:      unesc = CH_TAB;
			default: begin
				known = 1'b0;
				unesc = s_tdata;
			end
		endcase
	end

	assign is_blank = (s_tdata == CH_SPACE) || (s_tdata inside {[CH_TAB:CH_CR]});

	// Decode the incoming byte against the current phase.
	always_comb begin
		res0 = RES_NONE;
		res1 = RES_NONE;
		n_res = 2'd0;
		phase_d = phase_q;
		case (phase_q)
			PH_WS: begin
				if (is_blank) begin
					if (s_tlast) begin
						n_res = 2'd1;
						res0.string_done = 1'b1;
						res0.run_last = 1'b1;
					end
				end else if (s_tdata == CH_QUOTE) begin
					phase_d = PH_STR;
					if (s_tlast) begin
						n_res = 2'd1;
						res0.string_done = 1'b1;
						res0.run_last = 1'b1;
					end
				end else begin
					// Anything but whitespace or a quote first closes an empty string.
					phase_d = PH_DONE;
					n_res = 2'd1;
					res0.string_done = 1'b1;
					res0.run_last = s_tlast;
				end
			end
			PH_STR: begin
				if (s_tdata == CH_BSLASH) begin
					// A trailing backslash is dropped; the string just ends.
					phase_d = PH_ESC;
					if (s_tlast) begin
						n_res = 2'd1;
						res0.string_done = 1'b1;
						res0.run_last = 1'b1;
					end
				end else if (s_tdata == CH_QUOTE) begin
					phase_d = PH_DONE;
					n_res = 2'd1;
					res0.string_done = 1'b1;
					res0.run_last = s_tlast;
				end else begin
					n_res = 2'd1;
					res0 = '{out_byte: s_tdata, byte_valid: 1'b1,
						string_done: s_tlast, run_last: s_tlast};
				end
			end
			PH_ESC: begin
				phase_d = PH_STR;
				if (known) begin
					n_res = 2'd1;
					res0 = '{out_byte: unesc, byte_valid: 1'b1,
						string_done: s_tlast, run_last: s_tlast};
				end else begin
					// Unknown escape: emit the backslash, then the byte itself.
					n_res = 2'd2;
					res0 = '{out_byte: CH_BSLASH, byte_valid: 1'b1,
						string_done: 1'b0, run_last: 1'b0};
					res1 = '{out_byte: unesc, byte_valid: 1'b1,
						string_done: s_tlast, run_last: s_tlast};
				end
			end
			default: begin
				// String already done: only the final byte leaves a marker.
				if (s_tlast) begin
					n_res = 2'd1;
					res0.run_last = 1'b1;
				end
			end
		endcase
		if (s_tlast) begin
			phase_d = PH_WS;
		end
	end

	// Result queue: shift out at the head, write new results behind the
	// entries that remain after the pop.
	assign base = cnt_q - {1'b0, pop};
	assign cnt_d = base + (push ? n_res : 2'd0);

	always_comb begin
		for (int i = 0; i < QDEPTH; i++) begin
			if (pop && (i < QDEPTH - 1)) begin
				que_d[i] = que_q[(i < QDEPTH - 1) ? i + 1 : i];
			end else begin
				que_d[i] = que_q[i];
			end
			if (push && (n_res != 2'd0) && (2'(i) == base)) begin
				que_d[i] = res0;
			end
			if (push && (n_res == 2'd2) && (2'(i) == base + 2'd1)) begin
				que_d[i] = res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS;
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_d;
			if (push) begin
				phase_q <= phase_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		que_q <= que_d;
	end

	// A final byte always sends the decoder back to skipping whitespace.
	a_last_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(push && s_tlast) |=> (phase_q == PH_WS))
		else $error("phase not reset after final byte");

	// A final byte always produces at least one result.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(push && s_tlast) |=> (cnt_q != 2'd0))
		else $error("final byte produced no result");

	// Results without a decoded byte carry a zero byte.
	a_empty_result_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'h00))
		else $error("nonzero byte on result without byte_valid");

endmodule
